FILE: src/kcv_pkg.sv
// shared types, constants and fixed-point helpers of the kalman tracker
`default_nettype none
package kcv_pkg;

	localparam int FRAC = 16;

	typedef logic signed [31:0] fx_t;
	typedef logic signed [63:0] wide_t;

	localparam fx_t         FX_ONE     = 32'(64'sd1 <<< FRAC);
	localparam fx_t         FX_FOUR    = 32'(64'sd4 <<< FRAC);
	localparam fx_t         FX_MAX     = 32'sh7fffffff;
	localparam fx_t         FX_MIN     = 32'sh80000000;
	localparam wide_t       WIDE_MAX   = 64'sd2147483647;
	localparam wide_t       WIDE_MIN   = -64'sd2147483648;
	localparam logic [31:0] PNOISE_RST = 32'd655;
	localparam logic [31:0] MNOISE_RST = 32'd65536;

	// register indexes of the configuration port
	localparam logic REG_PNOISE = 1'b0;
	localparam logic REG_MNOISE = 1'b1;

	typedef enum logic [1:0] {
		ST_NORMAL   = 2'd0,
		ST_SEEDED   = 2'd1,
		ST_SINGULAR = 2'd2,
		ST_NO_INIT  = 2'd3
	} status_t;

	typedef enum logic [6:0] {
		PH_IDLE = 7'b0000001,
		PH_DET  = 7'b0000010,
		PH_DIV  = 7'b0000100,
		PH_GAIN = 7'b0001000,
		PH_UPD  = 7'b0010000,
		PH_COV  = 7'b0100000,
		PH_DONE = 7'b1000000
	} phase_t;

	// clamp a wide value to the 32-bit range
	function automatic fx_t sat64(input wide_t v);
		fx_t r;
		if (v > WIDE_MAX) r = FX_MAX;
		else if (v < WIDE_MIN) r = FX_MIN;
		else r = v[31:0];
		return r;
	endfunction

	function automatic fx_t sadd(input fx_t a, input fx_t b);
		wide_t s;
		s = 64'(a) + 64'(b);
		return sat64(s);
	endfunction

	function automatic fx_t ssub(input fx_t a, input fx_t b);
		wide_t s;
		s = 64'(a) - 64'(b);
		return sat64(s);
	endfunction

	function automatic fx_t sadd_u(input fx_t a, input logic [31:0] u);
		wide_t s;
		s = 64'(a) + $signed({32'd0, u});
		return sat64(s);
	endfunction

	// product back to FRAC fraction bits, ties toward plus infinity
	function automatic wide_t rnd(input wide_t p);
		return (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

endpackage
`default_nettype wire

FILE: src/kcv_in_if.sv
// request channel: predict or correct with a measurement
`default_nettype none
interface kcv_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic signed [31:0] meas_x;
	logic signed [31:0] meas_y;
	modport source(output valid, req_type, meas_x, meas_y, input ready);
	modport sink(input valid, req_type, meas_x, meas_y, output ready);
endinterface
`default_nettype wire

FILE: src/kcv_out_if.sv
// result channel: position estimate and status
`default_nettype none
interface kcv_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] est_x;
	logic signed [31:0] est_y;
	logic [1:0]  status;
	modport source(output valid, est_x, est_y, status, input ready);
	modport sink(input valid, est_x, est_y, status, output ready);
endinterface
`default_nettype wire

FILE: src/kcv_div.sv
// restoring divider: (num << FRAC) / den, truncated toward zero, saturated
`default_nettype none
module kcv_div import kcv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [32:0] num,
	input  fx_t                den,
	output logic               done,
	output fx_t                quo
);
	localparam int DW = 33 + FRAC;
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dvd_q;
	logic [DW-1:0] quo_q;
	logic [32:0]   rem_q;
	logic [31:0]   dmag_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [32:0] nmag;
	logic [32:0] shifted;
	logic        fits;

	assign nmag    = num[32] ? 33'(-num) : 33'(num);
	assign shifted = {rem_q[31:0], dvd_q[DW-1]};
	assign fits    = shifted >= {1'b0, dmag_q};

	// one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dvd_q  <= DW'(nmag) << FRAC;
				dmag_q <= den[31] ? 32'(-den) : 32'(den);
				neg_q  <= num[32] ^ den[31];
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? shifted - {1'b0, dmag_q} : shifted;
				quo_q <= {quo_q[DW-2:0], fits};
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// sign and clamp
	always_comb begin
		if (neg_q) begin
			if (quo_q > DW'(64'h80000000)) quo = FX_MIN;
			else quo = 32'(-quo_q[31:0]);
		end else begin
			if (quo_q > DW'(64'h7fffffff)) quo = FX_MAX;
			else quo = quo_q[31:0];
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

FILE: src/kalman_cv2d_tracker.sv
// Constant-velocity 2D Kalman tracker, Q16.16, one shared multiplier and divider.
// Predict, seed and predict-before-init go from accept through PH_DONE to the output register.
// Correct runs the determinant, four divider runs for the inverse, then the gain, update and
// covariance products; a singular correct ends after the determinant; a held result stalls
// the last step. One multiplier and the bit-serial divider serve all steps; one item at a time.
// arst_n clears the track to zero, covariance to identity, noise registers to defaults.
`default_nettype none
module kalman_cv2d_tracker import kcv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	kcv_in_if.sink      req_ch,
	kcv_out_if.source   res_ch,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_data
);
	phase_t      phase_q;
	logic [31:0] pnoise_q, mnoise_q;
	fx_t         ts_q [4];
	fx_t         cov_q [16];
	fx_t         pn_q [16];
	fx_t         k_q [8];
	fx_t         inv_q [4];
	logic        seeded_q;
	fx_t         yx_q, yy_q, det_q;
	wide_t       acc_q, prod_q;
	logic [3:0]  e_q;
	logic [1:0]  t_q;
	logic        mph_q;
	logic        dwait_q;
	status_t     status_q;
	logic        out_valid_q;
	fx_t         out_x_q, out_y_q;
	status_t     out_st_q;

	fx_t   s00, s01, s10, s11;
	fx_t   cp [16];
	fx_t   fp [16];
	fx_t   op_a, op_b, ikh, res_fx;
	wide_t mul_v, term, acc_new, acc_init;
	logic  last_t, last_e;
	logic  div_start, div_done;
	logic signed [32:0] div_num;
	fx_t   div_q;
	logic  load_out;

	// innovation covariance
	assign s00 = sadd_u(cov_q[0], mnoise_q);
	assign s11 = sadd_u(cov_q[5], mnoise_q);
	assign s01 = cov_q[1];
	assign s10 = cov_q[4];

	// predicted covariance F*P*F^T + Q
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			fp[j]      = sadd(cov_q[j], cov_q[8 + j]);
			fp[4 + j]  = sadd(cov_q[4 + j], cov_q[12 + j]);
			fp[8 + j]  = cov_q[8 + j];
			fp[12 + j] = cov_q[12 + j];
		end
		for (int i = 0; i < 4; i++) begin
			cp[4*i]     = sadd(fp[4*i], fp[4*i + 2]);
			cp[4*i + 1] = sadd(fp[4*i + 1], fp[4*i + 3]);
			cp[4*i + 2] = fp[4*i + 2];
			cp[4*i + 3] = fp[4*i + 3];
			cp[5*i]     = sadd_u(cp[5*i], pnoise_q);
		end
	end

	// entry of I - K*H for the covariance update
	always_comb begin
		if (!t_q[1]) ikh = ssub((e_q[3:2] == t_q) ? FX_ONE : '0, k_q[{e_q[3:2], t_q[0]}]);
		else ikh = (e_q[3:2] == t_q) ? FX_ONE : '0;
	end

	// operand select for the shared multiplier
	always_comb begin
		op_a = '0;
		op_b = '0;
		last_t = 1'b0;
		last_e = 1'b0;
		unique case (phase_q)
			PH_DET: begin
				op_a = t_q[0] ? s01 : s00;
				op_b = t_q[0] ? s10 : s11;
				last_t = t_q == 2'd1;
				last_e = 1'b1;
			end
			PH_GAIN: begin
				op_a = cov_q[{e_q[2:1], 1'b0, t_q[0]}];
				op_b = inv_q[{t_q[0], e_q[0]}];
				last_t = t_q == 2'd1;
				last_e = e_q == 4'd7;
			end
			PH_UPD: begin
				op_a = k_q[{e_q[1:0], t_q[0]}];
				op_b = t_q[0] ? yy_q : yx_q;
				last_t = t_q == 2'd1;
				last_e = e_q == 4'd3;
			end
			PH_COV: begin
				op_a = ikh;
				op_b = cov_q[{t_q, e_q[1:0]}];
				last_t = t_q == 2'd3;
				last_e = e_q == 4'd15;
			end
			default: begin
			end
		endcase
	end

	assign mul_v = op_a * op_b;

	// round and accumulate; determinant terms are clamped before subtraction
	always_comb begin
		if (phase_q == PH_DET) begin
			term = 64'(sat64(rnd(prod_q)));
			if (t_q[0]) term = -term;
		end else begin
			term = rnd(prod_q);
		end
		acc_new = acc_q + term;
		res_fx  = sat64(acc_new);
		if (phase_q == PH_GAIN && last_e) acc_init = 64'(ts_q[0]);
		else if (phase_q == PH_UPD && !last_e) acc_init = 64'(ts_q[2'(e_q[1:0] + 2'd1)]);
		else acc_init = '0;
	end

	// divider numerators for the 2x2 inverse
	always_comb begin
		unique case (e_q[1:0])
			2'd0: div_num = 33'(s11);
			2'd1: div_num = -33'(s01);
			2'd2: div_num = -33'(s10);
			default: div_num = 33'(s00);
		endcase
	end

	assign div_start = (phase_q == PH_DIV) && !dwait_q;

	kcv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_q)
	);

	// result register loads when it is free or being emptied
	assign load_out = (phase_q == PH_DONE) && (!out_valid_q || res_ch.ready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnoise_q <= PNOISE_RST;
			mnoise_q <= MNOISE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_PNOISE: pnoise_q <= cfg_data;
				REG_MNOISE: mnoise_q <= cfg_data;
			endcase
		end
	end

	// sequencer and track state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_NORMAL;
			e_q         <= '0;
			t_q         <= '0;
			mph_q       <= 1'b0;
			dwait_q     <= 1'b0;
			for (int i = 0; i < 4; i++) ts_q[i] <= '0;
			for (int i = 0; i < 16; i++) cov_q[i] <= (i % 5 == 0) ? FX_ONE : '0;
		end else begin
			if (load_out) out_valid_q <= 1'b1;
			else if (res_ch.ready) out_valid_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (req_ch.valid) begin
						if (!req_ch.req_type) begin
							phase_q <= PH_DONE;
							if (!seeded_q) begin
								status_q <= ST_NO_INIT;
							end else begin
								status_q <= ST_NORMAL;
								ts_q[0]  <= sadd(ts_q[0], ts_q[2]);
								ts_q[1]  <= sadd(ts_q[1], ts_q[3]);
								for (int i = 0; i < 16; i++) cov_q[i] <= cp[i];
							end
						end else if (!seeded_q) begin
							phase_q  <= PH_DONE;
							status_q <= ST_SEEDED;
							seeded_q <= 1'b1;
							ts_q[0]  <= req_ch.meas_x;
							ts_q[1]  <= req_ch.meas_y;
							ts_q[2]  <= '0;
							ts_q[3]  <= '0;
							// seed covariance diag(1, 1, 4, 4)
							for (int i = 0; i < 16; i++)
								cov_q[i] <= (i == 0 || i == 5) ? FX_ONE :
									(i == 10 || i == 15) ? FX_FOUR : '0;
						end else begin
							yx_q    <= ssub(req_ch.meas_x, ts_q[0]);
							yy_q    <= ssub(req_ch.meas_y, ts_q[1]);
							e_q     <= '0;
							t_q     <= '0;
							mph_q   <= 1'b0;
							acc_q   <= '0;
							phase_q <= PH_DET;
						end
					end
				end
				PH_DIV: begin
					if (!dwait_q) begin
						dwait_q <= 1'b1;
					end else if (div_done) begin
						inv_q[e_q[1:0]] <= div_q;
						dwait_q <= 1'b0;
						if (e_q == 4'd3) begin
							e_q     <= '0;
							t_q     <= '0;
							acc_q   <= '0;
							phase_q <= PH_GAIN;
						end else begin
							e_q <= e_q + 1'b1;
						end
					end
				end
				PH_DONE: begin
					if (load_out) begin
						out_x_q     <= (status_q == ST_NO_INIT) ? '0 : ts_q[0];
						out_y_q     <= (status_q == ST_NO_INIT) ? '0 : ts_q[1];
						out_st_q    <= status_q;
						phase_q     <= PH_IDLE;
					end
				end
				PH_DET, PH_GAIN, PH_UPD, PH_COV: begin
					if (!mph_q) begin
						prod_q <= mul_v;
						mph_q  <= 1'b1;
					end else begin
						mph_q <= 1'b0;
						if (!last_t) begin
							acc_q <= acc_new;
							t_q   <= t_q + 1'b1;
						end else begin
							t_q   <= '0;
							acc_q <= acc_init;
							e_q   <= last_e ? 4'd0 : e_q + 1'b1;
							// write back one finished sum
							unique case (phase_q)
								PH_DET: begin
									det_q <= res_fx;
									if (res_fx == '0) begin
										status_q <= ST_SINGULAR;
										phase_q  <= PH_DONE;
									end else begin
										dwait_q <= 1'b0;
										phase_q <= PH_DIV;
									end
								end
								PH_GAIN: begin
									k_q[e_q[2:0]] <= res_fx;
									if (last_e) phase_q <= PH_UPD;
								end
								PH_UPD: begin
									ts_q[e_q[1:0]] <= res_fx;
									if (last_e) phase_q <= PH_COV;
								end
								default: begin
									pn_q[e_q] <= res_fx;
									if (last_e) begin
										for (int i = 0; i < 15; i++) cov_q[i] <= pn_q[i];
										cov_q[15] <= res_fx;
										status_q  <= ST_NORMAL;
										phase_q   <= PH_DONE;
									end
								end
							endcase
						end
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	// channel outputs
	assign req_ch.ready  = phase_q == PH_IDLE;
	assign res_ch.valid  = out_valid_q;
	assign res_ch.est_x  = out_x_q;
	assign res_ch.est_y  = out_y_q;
	assign res_ch.status = out_st_q;

endmodule
`default_nettype wire

FILE: tb/kalman_cv2d_tracker_tb.sv
// testbench of the kalman tracker: directed and random predict and correct beats checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module kalman_cv2d_tracker_tb;
	import kcv_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic        req_type;
		logic [31:0] meas_x;
		logic [31:0] meas_y;
	} track_req_t;

	typedef struct packed {
		logic [31:0] est_x;
		logic [31:0] est_y;
		status_t     status;
	} track_est_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_idx;
	logic [31:0] cfg_data;

	kcv_in_if  req_ch();
	kcv_out_if res_ch();

	kalman_cv2d_tracker dut (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch), .res_ch(res_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	track_req_t pending_reqs[$];
	track_est_t expected_ests[$];
	int         errors;
	int         src_idle;
	int         snk_stall;
	logic       req_taken;
	int         cycles;

	// predictor copy of the tracker
	longint     pos_vel[4];
	longint     pcov[16];
	bit         is_seeded;
	longint     pnoise;
	longint     mnoise;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// rounded product, not clamped
	function automatic longint rmul(longint a, longint b);
		return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint sext(logic [31:0] v);
		return longint'($signed(v));
	endfunction

	// advance the predictor by one beat and return the estimate it causes
	task automatic track_step(input track_req_t rq, output track_est_t est);
		longint mx, my, yx, yy, s00, s01, s10, s11, det, acc;
		longint inv[4];
		longint gain[4][2];
		longint fp[4][4];
		longint pn[4][4];
		longint ikh[4][4];
		mx = sext(rq.meas_x);
		my = sext(rq.meas_y);
		if (!rq.req_type) begin
			if (!is_seeded) begin
				est = '{32'd0, 32'd0, ST_NO_INIT};
				return;
			end
			pos_vel[0] = clamp32(pos_vel[0] + pos_vel[2]);
			pos_vel[1] = clamp32(pos_vel[1] + pos_vel[3]);
			for (int j = 0; j < 4; j++) begin
				fp[0][j] = clamp32(pcov[j] + pcov[8 + j]);
				fp[1][j] = clamp32(pcov[4 + j] + pcov[12 + j]);
				fp[2][j] = pcov[8 + j];
				fp[3][j] = pcov[12 + j];
			end
			for (int i = 0; i < 4; i++) begin
				pn[i][0] = clamp32(fp[i][0] + fp[i][2]);
				pn[i][1] = clamp32(fp[i][1] + fp[i][3]);
				pn[i][2] = fp[i][2];
				pn[i][3] = fp[i][3];
			end
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					pcov[i * 4 + j] = (i == j) ? clamp32(pn[i][j] + pnoise) : pn[i][j];
			est = '{pos_vel[0][31:0], pos_vel[1][31:0], ST_NORMAL};
			return;
		end
		// first measurement seeds the track
		if (!is_seeded) begin
			pos_vel = '{mx, my, 0, 0};
			foreach (pcov[i]) pcov[i] = 0;
			pcov[0] = 64'sd1 <<< FRAC;
			pcov[5] = 64'sd1 <<< FRAC;
			pcov[10] = 64'sd4 <<< FRAC;
			pcov[15] = 64'sd4 <<< FRAC;
			is_seeded = 1'b1;
			est = '{rq.meas_x, rq.meas_y, ST_SEEDED};
			return;
		end
		yx = clamp32(mx - pos_vel[0]);
		yy = clamp32(my - pos_vel[1]);
		s00 = clamp32(pcov[0] + mnoise);
		s01 = pcov[1];
		s10 = pcov[4];
		s11 = clamp32(pcov[5] + mnoise);
		det = clamp32(clamp32(rmul(s00, s11)) - clamp32(rmul(s01, s10)));
		// singular innovation covariance leaves the track alone
		if (det == 0) begin
			est = '{pos_vel[0][31:0], pos_vel[1][31:0], ST_SINGULAR};
			return;
		end
		inv[0] = clamp32((s11 <<< FRAC) / det);
		inv[1] = clamp32(((-s01) <<< FRAC) / det);
		inv[2] = clamp32(((-s10) <<< FRAC) / det);
		inv[3] = clamp32((s00 <<< FRAC) / det);
		for (int i = 0; i < 4; i++) begin
			gain[i][0] = clamp32(rmul(pcov[i * 4], inv[0]) + rmul(pcov[i * 4 + 1], inv[2]));
			gain[i][1] = clamp32(rmul(pcov[i * 4], inv[1]) + rmul(pcov[i * 4 + 1], inv[3]));
		end
		for (int i = 0; i < 4; i++)
			pos_vel[i] = clamp32(pos_vel[i] + rmul(gain[i][0], yx) + rmul(gain[i][1], yy));
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				ikh[i][j] = clamp32(((i == j) ? (64'sd1 <<< FRAC) : 0)
					- ((j < 2) ? gain[i][j] : 0));
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int m = 0; m < 4; m++) acc += rmul(ikh[i][m], pcov[m * 4 + j]);
				pn[i][j] = clamp32(acc);
			end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				pcov[i * 4 + j] = pn[i][j];
		est = '{pos_vel[0][31:0], pos_vel[1][31:0], ST_NORMAL};
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_ch.valid || req_taken) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle) begin
					track_req_t rq;
					rq = pending_reqs.pop_front();
					req_ch.valid    <= 1'b1;
					req_ch.req_type <= rq.req_type;
					req_ch.meas_x   <= rq.meas_x;
					req_ch.meas_y   <= rq.meas_y;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= snk_stall);
		end
	end

	// accepted request beats, register writes and result checks
	always @(posedge clk) begin
		track_est_t est;
		track_est_t want;
		if (!arst_n) begin
			req_taken <= 1'b0;
		end else begin
			req_taken <= req_ch.valid && req_ch.ready;
			if (cfg_we) begin
				if (cfg_idx == REG_PNOISE) pnoise = longint'(cfg_data);
				else mnoise = longint'(cfg_data);
			end
			if (req_ch.valid && req_ch.ready) begin
				track_step('{req_ch.req_type, req_ch.meas_x, req_ch.meas_y}, est);
				expected_ests.push_back(est);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (expected_ests.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat x=%h y=%h status=%0d",
						$time, res_ch.est_x, res_ch.est_y, res_ch.status);
				end else begin
					want = expected_ests.pop_front();
					if (res_ch.est_x !== want.est_x) begin
						errors++;
						$display("%0t: est_x expected %h actual %h",
							$time, want.est_x, res_ch.est_x);
					end
					if (res_ch.est_y !== want.est_y) begin
						errors++;
						$display("%0t: est_y expected %h actual %h",
							$time, want.est_y, res_ch.est_y);
					end
					if (res_ch.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, res_ch.status);
					end
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("kalman_cv2d_tracker regression: fail");
			$finish;
		end
	end

	task automatic add_req(input logic kind, input logic [31:0] mx, input logic [31:0] my);
		pending_reqs.push_back('{kind, mx, my});
	endtask

	// random beat: measurements mostly near the track, some over the full range
	task automatic add_random_req();
		logic [31:0] mx;
		logic [31:0] my;
		if ($urandom_range(9) == 0) begin
			mx = $urandom;
			my = $urandom;
		end else begin
			mx = 32'(pos_vel[0] + $signed($urandom_range(2 ** 21) - 2 ** 20));
			my = 32'(pos_vel[1] + $signed($urandom_range(2 ** 21) - 2 ** 20));
		end
		add_req(1'($urandom_range(1)), mx, my);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || req_ch.valid || expected_ests.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we   <= 1'b0;
	endtask

	initial begin
		logic [31:0] pn_vals[8];
		logic [31:0] mn_vals[8];
		errors = 0;
		cycles = 0;
		src_idle = 0;
		snk_stall = 0;
		pnoise = PNOISE_RST;
		mnoise = MNOISE_RST;
		pos_vel = '{0, 0, 0, 0};
		foreach (pcov[i]) pcov[i] = (i % 5 == 0) ? (64'sd1 <<< FRAC) : 0;
		is_seeded = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_PNOISE;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = 1'b0;
		req_ch.meas_x = '0;
		req_ch.meas_y = '0;
		res_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: predict before init, seeding at extremes, saturation
		add_req(1'b0, 32'h7fffffff, 32'h80000000);
		add_req(1'b0, 32'h0, 32'h0);
		add_req(1'b1, 32'h7fffffff, 32'h80000000);
		add_req(1'b0, 32'h0, 32'h0);
		add_req(1'b1, 32'h80000000, 32'h7fffffff);
		add_req(1'b1, 32'h80000000, 32'h7fffffff);
		add_req(1'b0, 32'hffffffff, 32'hffffffff);
		add_req(1'b1, 32'h0, 32'h0);
		add_req(1'b1, 32'hffffffff, 32'h00000001);
		add_req(1'b0, 32'h0, 32'h0);
		add_req(1'b0, 32'h0, 32'h0);
		add_req(1'b1, 32'h00010000, 32'hffff0000);
		drain();
		// no measurement noise: the covariance collapses and corrections go singular
		write_reg(REG_MNOISE, 32'd0);
		write_reg(REG_PNOISE, 32'd0);
		add_req(1'b1, 32'h00020000, 32'h00030000);
		add_req(1'b1, 32'h00020000, 32'h00030000);
		add_req(1'b1, 32'h00021000, 32'h00031000);
		add_req(1'b0, 32'h0, 32'h0);
		add_req(1'b1, 32'h00022000, 32'h00032000);
		add_req(1'b1, 32'h00022000, 32'h00032000);
		drain();

		pn_vals = '{32'd655, 32'd0, 32'hffffffff, 32'd6554, 32'd0, 32'h00010000, 32'd655,
			32'h00400000};
		mn_vals = '{32'd65536, 32'd0, 32'hffffffff, 32'd1, 32'h00100000, 32'd0, 32'd3277,
			32'h7fffffff};
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_PNOISE, (ph == 3) ? $urandom : pn_vals[ph]);
			write_reg(REG_MNOISE, (ph == 6) ? $urandom : mn_vals[ph]);
			case (ph % 4)
				0: begin src_idle = 0;  snk_stall = 0;  end
				1: begin src_idle = 56; snk_stall = 0;  end
				2: begin src_idle = 0;  snk_stall = 56; end
				default: begin src_idle = 20; snk_stall = 20; end
			endcase
			for (int n = 0; n < 122; n++) begin
				// predictor state moves only on acceptance, so feed a few at a time
				while (pending_reqs.size() > 2) @(posedge clk);
				add_random_req();
			end
			drain();
		end

		if (errors == 0) begin
			$display("kalman_cv2d_tracker regression: pass");
		end else begin
			$display("kalman_cv2d_tracker regression: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
